[hw/rtl/boot_frame_receiver_core_assert.svh]
// assertion helpers for the boot frame receiver
// each check is clocked on clk and held off while rst is high
`ifndef BOOT_FRAME_RECEIVER_CORE_ASSERT_SVH
`define BOOT_FRAME_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication
`define BFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bfr_pkg.sv]
package bfr_pkg;

  localparam logic [7:0] START_BYTE      = 8'h7E;
  localparam logic [7:0] HANDSHAKE_BYTE  = 8'hA8;
  localparam logic [7:0] HANDSHAKE_REPLY = 8'h57;

  localparam int unsigned KEEP_DEPTH = 3;

  // header walk: command, three address bytes, two length bytes, then payload
  localparam logic [2:0] POS_COMMAND   = 3'd0;
  localparam logic [2:0] POS_ADDR_HI   = 3'd1;
  localparam logic [2:0] POS_ADDR_MID  = 3'd2;
  localparam logic [2:0] POS_ADDR_LO   = 3'd3;
  localparam logic [2:0] POS_LEN_HI    = 3'd4;
  localparam logic [2:0] POS_LEN_LO    = 3'd5;
  localparam logic [2:0] POS_PAYLOAD   = 3'd6;

  typedef enum logic [1:0] {
    EVT_HANDSHAKE = 2'd0,
    EVT_FRAME_OK  = 2'd1,
    EVT_SUM_ERROR = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  reply;
    logic [7:0]  command;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  payload0;
    logic [7:0]  payload1;
    logic [7:0]  payload2;
  } frame_event_t;

endpackage

[hw/rtl/boot_frame_receiver_core.sv]
// boot frame receiver: one serial byte per beat, at most one event beat out
// an event beat is registered from its byte: in the output register, or in the skid register on a stall
// throughput: one input beat per cycle while skid is empty; state update and event build are one pass
// an output register plus a skid register keep input flowing while out_ready is low
// reset (rst, synchronous, active high) drops out of any frame, clears all header
// state and the running sum, and empties both output registers
`include "boot_frame_receiver_core_assert.svh"

module boot_frame_receiver_core
  import bfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  reply_byte,
  output logic [7:0]  frame_command,
  output logic [23:0] frame_address,
  output logic [15:0] frame_length,
  output logic [7:0]  payload_first,
  output logic [7:0]  payload_second,
  output logic [7:0]  payload_third
);

  // frame parser state
  logic        in_frame, in_frame_next;
  logic [2:0]  header_position, header_position_next;
  logic [7:0]  captured_command, captured_command_next;
  logic [23:0] captured_address, captured_address_next;
  logic [15:0] captured_length, captured_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  kept_payload [KEEP_DEPTH];
  logic [7:0]  kept_payload_next [KEEP_DEPTH];

  // output side: presented beat and one skid slot
  logic         out_full;
  frame_event_t out_q;
  logic         skid_full;
  frame_event_t skid_q;

  logic         accept;
  logic         res_valid;
  frame_event_t res;

  // skid slot empty means any result of this beat has a home
  assign in_ready = !skid_full;
  assign accept   = in_valid && in_ready;

  // parser: next state and the event of the current byte
  always_comb begin
    in_frame_next         = in_frame;
    header_position_next  = header_position;
    captured_command_next = captured_command;
    captured_address_next = captured_address;
    captured_length_next  = captured_length;
    payload_count_next    = payload_count;
    running_sum_next      = running_sum;
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      kept_payload_next[i] = kept_payload[i];
    end
    res_valid    = 1'b0;
    res.kind     = EVT_HANDSHAKE;
    res.reply    = 8'h00;
    res.command  = captured_command;
    res.address  = captured_address;
    res.length   = captured_length;
    res.payload0 = kept_payload[0];
    res.payload1 = kept_payload[1];
    res.payload2 = kept_payload[2];

    if (!in_frame) begin
      if (rx_byte == START_BYTE) begin
        // open a frame with a clean header
        in_frame_next         = 1'b1;
        header_position_next  = POS_COMMAND;
        captured_command_next = 8'h00;
        captured_address_next = 24'h000000;
        captured_length_next  = 16'h0000;
        payload_count_next    = 16'h0000;
        running_sum_next      = 8'h00;
        for (int i = 0; i < KEEP_DEPTH; i++) begin
          kept_payload_next[i] = 8'h00;
        end
      end else if (rx_byte == HANDSHAKE_BYTE) begin
        // handshake answers with the reply byte, frame fields zero
        res_valid    = 1'b1;
        res.kind     = EVT_HANDSHAKE;
        res.reply    = HANDSHAKE_REPLY;
        res.command  = 8'h00;
        res.address  = 24'h000000;
        res.length   = 16'h0000;
        res.payload0 = 8'h00;
        res.payload1 = 8'h00;
        res.payload2 = 8'h00;
      end
    end else if (header_position == POS_PAYLOAD) begin
      if (payload_count < captured_length) begin
        for (int i = 0; i < KEEP_DEPTH; i++) begin
          if (payload_count == 16'(i)) begin
            kept_payload_next[i] = rx_byte;
          end
        end
        payload_count_next = payload_count + 16'd1;
        running_sum_next   = running_sum + rx_byte;
      end else begin
        // checksum byte closes the frame
        in_frame_next        = 1'b0;
        header_position_next = POS_COMMAND;
        res_valid            = 1'b1;
        if (running_sum != rx_byte) begin
          res.kind         = EVT_SUM_ERROR;
          running_sum_next = 8'h00;
        end else begin
          res.kind = EVT_FRAME_OK;
        end
      end
    end else begin
      unique case (header_position)
        POS_COMMAND:  captured_command_next = rx_byte;
        POS_ADDR_HI:  captured_address_next = {rx_byte, 16'h0000};
        POS_ADDR_MID: captured_address_next = {captured_address[23:16], rx_byte,
                                               captured_address[7:0]};
        POS_ADDR_LO:  captured_address_next = {captured_address[23:8], rx_byte};
        POS_LEN_HI:   captured_length_next  = {rx_byte, 8'h00};
        POS_LEN_LO: begin
          captured_length_next = {captured_length[15:8], rx_byte};
          payload_count_next   = 16'h0000;
        end
        default: ;
      endcase
      running_sum_next     = running_sum + rx_byte;
      header_position_next = header_position + 3'd1;
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      header_position  <= POS_COMMAND;
      captured_command <= 8'h00;
      captured_address <= 24'h000000;
      captured_length  <= 16'h0000;
      payload_count    <= 16'h0000;
      running_sum      <= 8'h00;
      for (int i = 0; i < KEEP_DEPTH; i++) begin
        kept_payload[i] <= 8'h00;
      end
    end else if (accept) begin
      in_frame         <= in_frame_next;
      header_position  <= header_position_next;
      captured_command <= captured_command_next;
      captured_address <= captured_address_next;
      captured_length  <= captured_length_next;
      payload_count    <= payload_count_next;
      running_sum      <= running_sum_next;
      for (int i = 0; i < KEEP_DEPTH; i++) begin
        kept_payload[i] <= kept_payload_next[i];
      end
    end
  end

  // output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_full && !out_ready) begin
      // presented beat stalls; park a new event in the skid slot
      if (accept && res_valid) begin
        skid_full <= 1'b1;
        skid_q    <= res;
      end
    end else if (skid_full) begin
      // in_ready is low here, so no new event competes
      out_full  <= 1'b1;
      out_q     <= skid_q;
      skid_full <= 1'b0;
    end else begin
      out_full <= accept && res_valid;
      if (accept && res_valid) begin
        out_q <= res;
      end
    end
  end

  assign out_valid      = out_full;
  assign event_kind     = out_q.kind;
  assign reply_byte     = out_q.reply;
  assign frame_command  = out_q.command;
  assign frame_address  = out_q.address;
  assign frame_length   = out_q.length;
  assign payload_first  = out_q.payload0;
  assign payload_second = out_q.payload1;
  assign payload_third  = out_q.payload2;

  // checks
  `BFR_ASSERT_NOW(a_skid_behind_out, skid_full, out_full,
    "skid slot holds a beat while the output register is empty")
  `BFR_ASSERT_NOW(a_idle_position, !in_frame, header_position == POS_COMMAND,
    "header position not reset outside a frame")
  `BFR_ASSERT_NOW(a_position_range, in_frame, header_position <= POS_PAYLOAD,
    "header position beyond payload phase")
  `BFR_ASSERT_NEXT(a_frame_end, accept && in_frame && res_valid, !in_frame,
    "frame still open after its closing event")

endmodule

[bench/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bfr_pkg::*;

  // a stream entry that is not a byte: the sender holds off until every
  // event already owed has come out of the block
  localparam int DRAIN_MARK   = -1;
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off, fills the skid path
  localparam int STUCK_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES  = 20;
  localparam int IDLE_PCT     = 16;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  event_kind;
  logic [7:0]  reply_byte;
  logic [7:0]  frame_command;
  logic [23:0] frame_address;
  logic [15:0] frame_length;
  logic [7:0]  payload_first;
  logic [7:0]  payload_second;
  logic [7:0]  payload_third;

  boot_frame_receiver_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_kind     (event_kind),
    .reply_byte     (reply_byte),
    .frame_command  (frame_command),
    .frame_address  (frame_address),
    .frame_length   (frame_length),
    .payload_first  (payload_first),
    .payload_second (payload_second),
    .payload_third  (payload_third)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bytes still to send, and events owed by the block in arrival order
  int           stream [$];
  frame_event_t events_due [$];

  int  fed;           // bytes put on the stream so far
  int  burst_at;      // stream byte index where the handshake burst begins
  int  bytes_in = 0;  // bytes accepted by the block
  int  cyc = 0;
  int  stuck = 0;
  int  bad_count = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  wire quiet = (cyc >= 600) && (cyc < 1100);  // stretch with no idling on either side

  // parser state mirrored on the bench side
  bit         framing;
  logic [2:0] hdr_pos;
  logic [7:0] cmd_q;
  logic [23:0] addr_q;
  logic [15:0] len_q;
  logic [15:0] pay_cnt;
  logic [7:0] sum_q;
  logic [7:0] keep [KEEP_DEPTH];

  // ---------------------------------------------------------------------------
  // parser prediction: one accepted byte in, zero or one event owed
  // ---------------------------------------------------------------------------
  task automatic parse_byte(input logic [7:0] b);
    frame_event_t ev;
    ev = '0;
    if (!framing) begin
      if (b == START_BYTE) begin
        // start byte wipes the header, the sum and the kept payload
        framing = 1'b1;
        hdr_pos = POS_COMMAND;
        cmd_q   = '0;
        addr_q  = '0;
        len_q   = '0;
        pay_cnt = '0;
        sum_q   = '0;
        foreach (keep[i]) keep[i] = '0;
      end else if (b == HANDSHAKE_BYTE) begin
        // handshake carries only the reply, all frame fields zero
        ev.kind  = EVT_HANDSHAKE;
        ev.reply = HANDSHAKE_REPLY;
        events_due.push_back(ev);
      end
      // any other byte outside a frame is dropped
    end else begin
      case (hdr_pos)
        POS_COMMAND:  cmd_q = b;
        POS_ADDR_HI:  addr_q = {b, 16'h0000};
        POS_ADDR_MID: addr_q[15:8] = b;
        POS_ADDR_LO:  addr_q[7:0] = b;
        POS_LEN_HI:   len_q = {b, 8'h00};
        POS_LEN_LO: begin
          len_q[7:0] = b;
          pay_cnt    = '0;
        end
        default: begin
          if (pay_cnt < len_q) begin
            // payload beat: summed always, kept only for the first few
            if (pay_cnt < KEEP_DEPTH) keep[pay_cnt[1:0]] = b;
            pay_cnt = pay_cnt + 16'd1;
            sum_q   = sum_q + b;
          end else begin
            // checksum beat closes the frame either way
            ev.kind     = (sum_q == b) ? EVT_FRAME_OK : EVT_SUM_ERROR;
            ev.command  = cmd_q;
            ev.address  = addr_q;
            ev.length   = len_q;
            ev.payload0 = keep[0];
            ev.payload1 = keep[1];
            ev.payload2 = keep[2];
            events_due.push_back(ev);
            if (sum_q != b) sum_q = '0;
            framing = 1'b0;
            hdr_pos = POS_COMMAND;
          end
        end
      endcase
      if (framing && hdr_pos != POS_PAYLOAD) begin
        sum_q   = sum_q + b;
        hdr_pos = hdr_pos + 3'd1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stream building
  // ---------------------------------------------------------------------------
  function automatic void feed(input logic [7:0] b);
    stream.push_back(int'(b));
    fed++;
  endfunction

  // mostly random, with the start and handshake codes showing up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0:       return START_BYTE;
      1:       return HANDSHAKE_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_frame(input logic [7:0] cmd, input logic [23:0] addr,
                           input logic [15:0] len, input bit good);
    logic [7:0] hdr [6];
    logic [7:0] sum;
    logic [7:0] pb;
    hdr = '{cmd, addr[23:16], addr[15:8], addr[7:0], len[15:8], len[7:0]};
    sum = '0;
    feed(START_BYTE);
    foreach (hdr[i]) begin
      feed(hdr[i]);
      sum = sum + hdr[i];
    end
    repeat (len) begin
      pb = pick_byte();
      feed(pb);
      sum = sum + pb;
    end
    // a bad frame gets a checksum off by a nonzero amount
    feed(good ? sum : sum ^ 8'($urandom_range(1, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // sender: offers the next stream byte, keeps it steady until accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    int nxt;
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(rx_byte);
        bytes_in <= bytes_in + 1;
      end
      if (!in_valid || in_ready) begin
        // drain pause ends once nothing is owed
        if (stream.size() != 0 && stream[0] == DRAIN_MARK && events_due.size() == 0)
          void'(stream.pop_front());
        if (stream.size() != 0 && stream[0] != DRAIN_MARK &&
            (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = stream.pop_front();
          in_valid <= 1'b1;
          rx_byte  <= nxt[7:0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off during the handshake burst
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_in >= burst_at) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // event checker: each event beat against the oldest owed event
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    frame_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected event beat: kind=%0d reply=%h cmd=%h addr=%h len=%h",
                   event_kind, reply_byte, frame_command, frame_address, frame_length);
        bad_count++;
      end else begin
        want = events_due.pop_front();
        if (event_kind !== want.kind || reply_byte !== want.reply ||
            frame_command !== want.command || frame_address !== want.address ||
            frame_length !== want.length || payload_first !== want.payload0 ||
            payload_second !== want.payload1 || payload_third !== want.payload2) begin
          if (bad_count < 10) begin
            $display("event mismatch at cycle %0d", cyc);
            $display("  expected kind=%0d reply=%h cmd=%h addr=%h len=%h pay=%h %h %h",
                     want.kind, want.reply, want.command, want.address, want.length,
                     want.payload0, want.payload1, want.payload2);
            $display("  actual   kind=%0d reply=%h cmd=%h addr=%h len=%h pay=%h %h %h",
                     event_kind, reply_byte, frame_command, frame_address, frame_length,
                     payload_first, payload_second, payload_third);
          end
          bad_count++;
        end
      end
    end
  end

  // cycle count and hang detection
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("boot_frame_receiver_core test failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int work;
    int sel;
    int n;
    logic [15:0] len;
    logic [7:0] b;

    framing = 1'b0;
    hdr_pos = POS_COMMAND;
    cmd_q   = '0;
    addr_q  = '0;
    len_q   = '0;
    pay_cnt = '0;
    sum_q   = '0;
    foreach (keep[i]) keep[i] = '0;
    fed = 0;

    // directed: ignored bytes, a handshake, header and length extremes,
    // start and handshake codes inside a frame, good and bad checksums
    feed(8'h00);
    feed(8'hFF);
    feed(HANDSHAKE_REPLY);
    feed(HANDSHAKE_BYTE);
    add_frame(8'h00, 24'h000000, 16'd0, 1'b1);
    add_frame(8'hFF, 24'hFFFFFF, 16'd0, 1'b0);
    add_frame(START_BYTE, {START_BYTE, HANDSHAKE_BYTE, HANDSHAKE_REPLY}, 16'd1, 1'b1);
    add_frame(HANDSHAKE_BYTE, 24'h123456, 16'd2, 1'b0);
    add_frame(8'h5A, 24'hA5A5A5, 16'd3, 1'b1);
    add_frame(8'hC3, 24'h800001, 16'd5, 1'b1);

    // burst of handshakes while the receiver holds off, then drain
    burst_at = fed;
    repeat (16) feed(HANDSHAKE_BYTE);
    stream.push_back(DRAIN_MARK);

    // random: mostly well-formed frames, some handshakes, noise and bad frames;
    // a few long frames push the payload count past one byte
    work = 0;
    while (work < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        n = $urandom_range(99);
        if (n < 70)      len = 16'($urandom_range(0, 3));
        else if (n < 97) len = 16'($urandom_range(4, 20));
        else             len = 16'($urandom_range(256, 290));
        add_frame(pick_byte(), {pick_byte(), pick_byte(), pick_byte()}, len,
                  $urandom_range(99) < 75);
        work += len + 8;
      end else if (sel < 80) begin
        n = $urandom_range(1, 4);
        repeat (n) feed(HANDSHAKE_BYTE);
        work += n;
      end else if (sel < 93) begin
        // stray byte outside a frame; never a start byte
        do b = 8'($urandom_range(255)); while (b == START_BYTE);
        feed(b);
        work++;
      end else if (sel < 98) begin
        // doubled start byte with a broken checksum
        len = 16'($urandom_range(0, 3));
        add_frame(START_BYTE, {pick_byte(), pick_byte(), pick_byte()}, len, 1'b0);
        work += len + 8;
      end else begin
        stream.push_back(DRAIN_MARK);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (stream.size() != 0 || in_valid || events_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_count == 0 && events_due.size() == 0) begin
      $display("boot_frame_receiver_core test passed");
    end else begin
      $display("boot_frame_receiver_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
